[sv/tcpi_pkg.sv]
// Shared types, constants and the control store for the traction control PI trim block.
// Used by every module of the block; depends on nothing.

package tcpi_pkg;

  localparam int unsigned StepW     = 4;
  localparam int unsigned DivW      = 50;
  localparam int unsigned DivisorW  = 10;
  localparam int unsigned DivCountW = 5;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = 72;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 31;

  // pi/30 * 256000 in Q16
  localparam logic [30:0] Rpmk = 31'd1756905951;
  // integral term divides by 1000 after a 14 bit shift
  localparam logic [DivisorW-1:0] IntegDivisor = 10'd1000;
  // quotient bit pairs per division: 32 bit speed quotient, 50 bit trim quotient
  localparam logic [DivCountW-1:0] RawDivSteps  = 5'd16;
  localparam logic [DivCountW-1:0] TrimDivSteps = 5'd25;
  localparam logic [15:0] WeightOne = 16'd32768;

  localparam logic [15:0] FilterWeightRst   = 16'd8192;
  localparam logic [30:0] AccelThresholdRst = 31'd51200;
  localparam logic [15:0] PropGainRst       = 16'd4096;
  localparam logic [15:0] IntegGainRst      = 16'd4096;
  localparam logic [14:0] MaxTrimRst        = 15'd3200;

  typedef enum logic [CfgIndexW-1:0] {
    CfgFilterWeight   = 3'd0,
    CfgAccelThreshold = 3'd1,
    CfgPropGain       = 3'd2,
    CfgIntegGain      = 3'd3,
    CfgMaxTrim        = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OpNop,
    OpLoad,
    OpSpeed,
    OpDivRaw,
    OpRaw,
    OpEma,
    OpErr,
    OpIntAdd,
    OpPropAcc,
    OpLoSave,
    OpDivTrim,
    OpTrimSum,
    OpOut
  } op_e;

  typedef enum logic [2:0] {
    MulNone,
    MulRpm,
    MulEma,
    MulInteg,
    MulProp,
    MulIntLo,
    MulIntHi
  } mul_sel_e;

  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondNoInput,
    CondDtZero,
    CondErrLe0,
    CondDivBusy,
    CondOutFull
  } cond_e;

  typedef struct packed {
    op_e              op;
    mul_sel_e         mul;
    cond_e            cond;
    logic [StepW-1:0] target;
  } uop_t;

  typedef struct packed {
    logic no_input;
    logic dt_zero;
    logic err_le0;
    logic div_busy;
    logic out_full;
  } status_t;

  typedef struct packed {
    logic                 start;
    logic [DivW-1:0]      dividend;
    logic [DivisorW-1:0]  divisor;
    logic [DivCountW-1:0] steps;
  } div_req_t;

  localparam logic [StepW-1:0] StepIdle     = 4'd0;
  localparam logic [StepW-1:0] StepRawWait  = 4'd3;
  localparam logic [StepW-1:0] StepEma      = 4'd5;
  localparam logic [StepW-1:0] StepTrimWait = 4'd13;
  localparam logic [StepW-1:0] StepOut      = 4'd15;

  // Control store. A taken condition jumps to target, otherwise the step
  // counter advances; the last step wraps back to idle.
  function automatic uop_t uop_rom(input logic [StepW-1:0] step);
    uop_t u;
    case (step)
      4'd0:  u = '{op: OpLoad,    mul: MulNone,  cond: CondNoInput, target: StepIdle};
      4'd1:  u = '{op: OpSpeed,   mul: MulRpm,   cond: CondDtZero,  target: StepEma};
      4'd2:  u = '{op: OpDivRaw,  mul: MulNone,  cond: CondNever,   target: StepIdle};
      4'd3:  u = '{op: OpNop,     mul: MulNone,  cond: CondDivBusy, target: StepRawWait};
      4'd4:  u = '{op: OpRaw,     mul: MulNone,  cond: CondNever,   target: StepIdle};
      4'd5:  u = '{op: OpNop,     mul: MulEma,   cond: CondNever,   target: StepIdle};
      4'd6:  u = '{op: OpEma,     mul: MulNone,  cond: CondNever,   target: StepIdle};
      4'd7:  u = '{op: OpErr,     mul: MulNone,  cond: CondErrLe0,  target: StepOut};
      4'd8:  u = '{op: OpNop,     mul: MulInteg, cond: CondNever,   target: StepIdle};
      4'd9:  u = '{op: OpIntAdd,  mul: MulProp,  cond: CondNever,   target: StepIdle};
      4'd10: u = '{op: OpPropAcc, mul: MulIntLo, cond: CondNever,   target: StepIdle};
      4'd11: u = '{op: OpLoSave,  mul: MulIntHi, cond: CondNever,   target: StepIdle};
      4'd12: u = '{op: OpDivTrim, mul: MulNone,  cond: CondNever,   target: StepIdle};
      4'd13: u = '{op: OpNop,     mul: MulNone,  cond: CondDivBusy, target: StepTrimWait};
      4'd14: u = '{op: OpTrimSum, mul: MulNone,  cond: CondNever,   target: StepIdle};
      4'd15: u = '{op: OpOut,     mul: MulNone,  cond: CondOutFull, target: StepOut};
      default: u = '{op: OpNop,   mul: MulNone,  cond: CondAlways,  target: StepIdle};
    endcase
    return u;
  endfunction

endpackage

[sv/tcpi_div.sv]
// Shared unsigned divider, restoring, two quotient bits per cycle.
// Depends on tcpi_pkg for widths and the request struct.

module tcpi_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcpi_pkg::div_req_t             req_i,
  output logic [tcpi_pkg::DivW-1:0]      quo_o,
  output logic                           busy_o
);

  logic [tcpi_pkg::DivW-1:0]      quo_q, quo_d;
  logic [tcpi_pkg::DivisorW-1:0]  rem_q, rem_d;
  logic [tcpi_pkg::DivisorW-1:0]  den_q;
  logic [tcpi_pkg::DivCountW-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;

  logic [tcpi_pkg::DivisorW:0] r_a, r_b, s_a, s_b;
  logic                        ge_a, ge_b;

  always_comb begin
    r_a  = {rem_q, quo_q[tcpi_pkg::DivW-1]};
    ge_a = r_a >= {1'b0, den_q};
    s_a  = ge_a ? r_a - {1'b0, den_q} : r_a;
    r_b  = {s_a[tcpi_pkg::DivisorW-1:0], quo_q[tcpi_pkg::DivW-2]};
    ge_b = r_b >= {1'b0, den_q};
    s_b  = ge_b ? r_b - {1'b0, den_q} : r_b;
  end

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[tcpi_pkg::DivW-3:0], ge_a, ge_b};
      rem_d  = s_b[tcpi_pkg::DivisorW-1:0];
      cnt_d  = cnt_q - 1'b1;
      busy_d = cnt_q != tcpi_pkg::DivCountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      den_q <= req_i.divisor;
    end
  end

  assign quo_o  = quo_q;
  assign busy_o = busy_q;

endmodule

[sv/tcpi_seq.sv]
// Step counter and control store lookup with conditional jumps.
// Depends on tcpi_pkg for the control word, status struct and program.

module tcpi_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcpi_pkg::status_t status_i,
  output tcpi_pkg::uop_t    uop_o
);

  logic [tcpi_pkg::StepW-1:0] step_q, step_d;
  logic                       take;

  assign uop_o = tcpi_pkg::uop_rom(step_q);

  always_comb begin
    case (uop_o.cond)
      tcpi_pkg::CondNever:   take = 1'b0;
      tcpi_pkg::CondAlways:  take = 1'b1;
      tcpi_pkg::CondNoInput: take = status_i.no_input;
      tcpi_pkg::CondDtZero:  take = status_i.dt_zero;
      tcpi_pkg::CondErrLe0:  take = status_i.err_le0;
      tcpi_pkg::CondDivBusy: take = status_i.div_busy;
      tcpi_pkg::CondOutFull: take = status_i.out_full;
      default:               take = 1'b0;
    endcase
    step_d = take ? uop_o.target : step_q + tcpi_pkg::StepW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= tcpi_pkg::StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

[sv/tcpi_dp.sv]
// Datapath: config registers, filter and integrator state, shared multiplier,
// input capture and output register. Depends on tcpi_pkg; driven by tcpi_seq.

module tcpi_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tcpi_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [tcpi_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  input  logic [tcpi_pkg::InDataW-1:0]       s_tdata_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [tcpi_pkg::OutDataW-1:0]      m_tdata_o,
  input  tcpi_pkg::uop_t                     uop_i,
  output tcpi_pkg::status_t                  status_o,
  output tcpi_pkg::div_req_t                 div_req_o,
  input  logic [tcpi_pkg::DivW-1:0]          div_quo_i,
  input  logic                               div_busy_i
);

  // configuration
  logic [15:0] fw_q, pg_q, ig_q;
  logic [30:0] thr_q;
  logic [14:0] mt_q;

  // captured request
  logic signed [15:0] speed_q, treq_q, tpl_q;
  logic        [9:0]  dt_q;

  // loop state
  logic signed [15:0] last_speed_q, last_speed_d;
  logic signed [31:0] last_raw_q, last_raw_d;
  logic signed [31:0] y_q, y_d;
  logic        [46:0] integ_q, integ_d;

  // scratch
  logic        neg_q, neg_d;
  logic [30:0] err_q, err_d;
  logic [32:0] acc_q, acc_d;
  logic [39:0] lo_q, lo_d;
  logic [14:0] trim_q, trim_d;

  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] prod_q, prod_d;

  logic                                out_valid_q, out_valid_d;
  logic [tcpi_pkg::OutDataW-1:0]       out_data_q;

  logic signed [16:0] dv, dv_neg;
  logic        [15:0] dv_mag;
  logic signed [32:0] ema_diff, err_full;
  logic        [15:0] w_eff;
  logic               err_le0;
  logic signed [31:0] raw_pos, raw_val;
  logic        [46:0] raw_num;
  logic        [47:0] integ_sum;
  logic        [40:0] trim_sum;
  logic signed [15:0] trim_s, trim_fin;
  logic signed [16:0] tout;
  logic               accept, out_full, out_load;

  assign s_tready_o = uop_i.op == tcpi_pkg::OpLoad;
  assign accept     = s_tready_o & s_tvalid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= tcpi_pkg::FilterWeightRst;
      thr_q <= tcpi_pkg::AccelThresholdRst;
      pg_q  <= tcpi_pkg::PropGainRst;
      ig_q  <= tcpi_pkg::IntegGainRst;
      mt_q  <= tcpi_pkg::MaxTrimRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tcpi_pkg::CfgFilterWeight:   fw_q  <= cfg_wdata_i[15:0];
        tcpi_pkg::CfgAccelThreshold: thr_q <= cfg_wdata_i;
        tcpi_pkg::CfgPropGain:       pg_q  <= cfg_wdata_i[15:0];
        tcpi_pkg::CfgIntegGain:      ig_q  <= cfg_wdata_i[15:0];
        tcpi_pkg::CfgMaxTrim:        mt_q  <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // operand preparation
  always_comb begin
    dv       = {speed_q[15], speed_q} - {last_speed_q[15], last_speed_q};
    dv_neg   = -dv;
    dv_mag   = dv[16] ? dv_neg[15:0] : dv[15:0];
    ema_diff = {last_raw_q[31], last_raw_q} - {y_q[31], y_q};
    w_eff    = (fw_q > tcpi_pkg::WeightOne) ? tcpi_pkg::WeightOne : fw_q;
    err_full = {y_q[31], y_q} - {2'b00, thr_q};
    err_le0  = err_full[32] | (err_full == '0);
    raw_pos  = {1'b0, div_quo_i[30:0]};
    raw_val  = neg_q ? -raw_pos : raw_pos;
    // rounding: add half the divisor before the shift and divide
    raw_num  = prod_q[46:0] + {22'b0, dt_q, 15'b0};
    integ_sum = {1'b0, integ_q} + {7'b0, prod_q[40:0]};
    trim_sum  = {8'b0, acc_q} + {1'b0, div_quo_i[39:0]};
    trim_s    = {1'b0, trim_q};
    trim_fin  = (treq_q < trim_s) ? treq_q : trim_s;
    tout      = {tpl_q[15], tpl_q} - {trim_fin[15], trim_fin};
  end

  // shared multiplier, product registered
  always_comb begin
    case (uop_i.mul)
      tcpi_pkg::MulRpm: begin
        mul_a = {3'b0, tcpi_pkg::Rpmk};
        mul_b = {1'b0, dv_mag};
      end
      tcpi_pkg::MulEma: begin
        mul_a = {ema_diff[32], ema_diff};
        mul_b = {1'b0, w_eff};
      end
      tcpi_pkg::MulInteg: begin
        mul_a = {3'b0, err_q};
        mul_b = {7'b0, dt_q};
      end
      tcpi_pkg::MulProp: begin
        mul_a = {3'b0, err_q};
        mul_b = {1'b0, pg_q};
      end
      tcpi_pkg::MulIntLo: begin
        mul_a = {10'b0, integ_q[23:0]};
        mul_b = {1'b0, ig_q};
      end
      tcpi_pkg::MulIntHi: begin
        mul_a = {11'b0, integ_q[46:24]};
        mul_b = {1'b0, ig_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = 51'(mul_a) * 51'(mul_b);
  end

  assign out_full = out_valid_q & ~m_tready_i;
  assign out_load = (uop_i.op == tcpi_pkg::OpOut) & ~out_full;

  always_comb begin
    last_speed_d = last_speed_q;
    last_raw_d   = last_raw_q;
    y_d          = y_q;
    integ_d      = integ_q;
    neg_d        = neg_q;
    err_d        = err_q;
    acc_d        = acc_q;
    lo_d         = lo_q;
    trim_d       = trim_q;
    div_req_o    = '{start: 1'b0, dividend: '0, divisor: dt_q,
                     steps: tcpi_pkg::RawDivSteps};
    case (uop_i.op)
      tcpi_pkg::OpSpeed: begin
        last_speed_d = speed_q;
        neg_d        = dv[16];
      end
      tcpi_pkg::OpDivRaw: begin
        div_req_o = '{start: 1'b1, dividend: {1'b0, raw_num[46:16], 18'b0},
                      divisor: dt_q, steps: tcpi_pkg::RawDivSteps};
      end
      tcpi_pkg::OpRaw: begin
        last_raw_d = raw_val;
      end
      tcpi_pkg::OpEma: begin
        // floor of the product over 2^15
        y_d = y_q + $signed(prod_q[46:15]);
      end
      tcpi_pkg::OpErr: begin
        err_d = err_full[30:0];
        if (err_le0) begin
          integ_d = '0;
          trim_d  = '0;
        end
      end
      tcpi_pkg::OpIntAdd: begin
        integ_d = integ_sum[47] ? '1 : integ_sum[46:0];
      end
      tcpi_pkg::OpPropAcc: begin
        acc_d = prod_q[46:14];
      end
      tcpi_pkg::OpLoSave: begin
        lo_d = prod_q[39:0];
      end
      tcpi_pkg::OpDivTrim: begin
        // (hi * 2^24 + lo) >> 14, then divided by 1000
        div_req_o = '{start: 1'b1,
                      dividend: {1'b0, prod_q[38:0], 10'b0} + {24'b0, lo_q[39:14]},
                      divisor: tcpi_pkg::IntegDivisor, steps: tcpi_pkg::TrimDivSteps};
      end
      tcpi_pkg::OpTrimSum: begin
        trim_d = (trim_sum > {26'b0, mt_q}) ? mt_q : trim_sum[14:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = (out_valid_q & ~m_tready_i) | out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_speed_q <= '0;
      last_raw_q   <= '0;
      y_q          <= '0;
      integ_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      last_speed_q <= last_speed_d;
      last_raw_q   <= last_raw_d;
      y_q          <= y_d;
      integ_q      <= integ_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg_d;
    err_q  <= err_d;
    acc_q  <= acc_d;
    lo_q   <= lo_d;
    trim_q <= trim_d;
    if (accept) begin
      speed_q <= $signed(s_tdata_i[15:0]);
      dt_q    <= s_tdata_i[25:16];
      treq_q  <= $signed(s_tdata_i[41:26]);
      tpl_q   <= $signed(s_tdata_i[57:42]);
    end
    if (out_load) begin
      out_data_q <= {7'b0, tout, trim_fin, y_q};
    end
  end

  assign status_o = '{no_input: ~s_tvalid_i, dt_zero: dt_q == '0, err_le0: err_le0,
                      div_busy: div_busy_i, out_full: out_full};

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

[sv/traction_control_pi_trim.sv]
// Traction control PI trim. A zero tick below threshold runs no division; the shared
// divider (two quotient bits a cycle) sets the time from request to result when both
// divisions run. Requests are worked one at a time, a new one after the last result is loaded;
// the next request is taken while a result waits in the output register.
// Reset (async, active low) clears the step counter, divider, filter and integrator
// state and loads the register defaults; no clearing pass.

module traction_control_pi_trim (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tcpi_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [tcpi_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [15:0] speed_rpm, [25:16] tick_ms, [41:26] torque_request,
  // [57:42] limited_torque, [63:58] zero
  input  logic [tcpi_pkg::InDataW-1:0]       s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [31:0] accel_filtered, [47:32] trim_torque, [64:48] torque_out, [71:65] zero
  output logic [tcpi_pkg::OutDataW-1:0]      m_axis_tdata_o
);

  tcpi_pkg::uop_t             uop;
  tcpi_pkg::status_t          status;
  tcpi_pkg::div_req_t         div_req;
  logic [tcpi_pkg::DivW-1:0]  div_quo;
  logic                       div_busy;

  tcpi_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .uop_o    (uop)
  );

  tcpi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .quo_o  (div_quo),
    .busy_o (div_busy)
  );

  tcpi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .uop_i       (uop),
    .status_o    (status),
    .div_req_o   (div_req),
    .div_quo_i   (div_quo),
    .div_busy_i  (div_busy)
  );

endmodule

[sv/tcpi_checker.sv]
// Port-level checks for traction_control_pi_trim, attached by bind.
// Depends on tcpi_pkg for the data width.

module tcpi_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [tcpi_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

  // one request in work at a time
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while one is in work");

  // finishing a result frees the input side at once
  a_result_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("input not ready after result");

endmodule

bind traction_control_pi_trim tcpi_checker u_checker (.*);

[sim/tcpi_trim_checker.sv]
// Checker for the traction control PI trim block: watches the register port and both
// streams, predicts each result and compares it. Depends on tcpi_pkg.
`timescale 1ns / 100ps

module tcpi_trim_checker
  import tcpi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  output int unsigned         pending_o,
  output int unsigned         mismatches_o
);

  localparam longint RpmScale  = 64'sd1756905951;
  localparam longint ExcessMax = 64'sd140737488355327;
  localparam int unsigned PrintCap = 40;

  typedef struct packed {
    logic signed [31:0] accel;
    logic signed [15:0] trim;
    logic signed [16:0] torque;
  } trim_result_t;

  // register copies
  logic [15:0] weight;
  logic [30:0] threshold;
  logic [15:0] kp;
  logic [15:0] ki;
  logic [14:0] trim_cap;

  // controller state
  logic signed [15:0] prev_speed;
  longint prev_raw;
  longint accel_ema;
  longint excess_sum;

  trim_result_t trim_due_q[$];
  int unsigned mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic longint div_floor(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic trim_result_t trim_step(input logic [InDataW-1:0] req);
    logic signed [15:0] speed;
    logic [9:0] dt;
    logic signed [15:0] treq;
    logic signed [15:0] tpl;
    longint num, den, mag, q, raw, w, err, trim, tout;
    trim_result_t r;
    speed = req[15:0];
    dt    = req[25:16];
    treq  = req[41:26];
    tpl   = req[57:42];

    if (dt != 0) begin
      num = (longint'(speed) - longint'(prev_speed)) * RpmScale;
      den = longint'(dt) * 65536;
      mag = (num < 0) ? -num : num;
      q   = (mag + den / 2) / den;
      raw = (num < 0) ? -q : q;
    end else begin
      // zero tick: hold the last raw acceleration
      raw = prev_raw;
    end
    prev_speed = speed;
    prev_raw   = raw;

    w = (weight > 16'd32768) ? 64'sd32768 : longint'(weight);
    accel_ema = accel_ema + div_floor((raw - accel_ema) * w, 32768);

    trim = 0;
    err  = accel_ema - longint'(threshold);
    if (err > 0) begin
      excess_sum = excess_sum + err * longint'(dt);
      if (excess_sum > ExcessMax) excess_sum = ExcessMax;
      trim = (longint'(kp) * err) / 16384 + (longint'(ki) * excess_sum) / 16384000;
    end else begin
      excess_sum = 0;
    end

    if (trim > longint'(trim_cap)) trim = longint'(trim_cap);
    if (trim > longint'(treq)) trim = longint'(treq);
    tout = longint'(tpl) - trim;

    r.accel  = accel_ema[31:0];
    r.trim   = trim[15:0];
    r.torque = tout[16:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PrintCap) $display("%0t: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    trim_result_t seen;
    trim_result_t want;
    if (!rst_ni) begin
      weight     = 16'd8192;
      threshold  = 31'd51200;
      kp         = 16'd4096;
      ki         = 16'd4096;
      trim_cap   = 15'd3200;
      prev_speed = '0;
      prev_raw   = 0;
      accel_ema  = 0;
      excess_sum = 0;
      trim_due_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgFilterWeight:   weight    = cfg_wdata_i[15:0];
          CfgAccelThreshold: threshold = cfg_wdata_i[30:0];
          CfgPropGain:       kp        = cfg_wdata_i[15:0];
          CfgIntegGain:      ki        = cfg_wdata_i[15:0];
          CfgMaxTrim:        trim_cap  = cfg_wdata_i[14:0];
          default: ;
        endcase
      end

      // results first, so a request taken in the same cycle cannot be matched
      if (m_tvalid_i && m_tready_i) begin
        seen.accel  = m_tdata_i[31:0];
        seen.trim   = m_tdata_i[47:32];
        seen.torque = m_tdata_i[64:48];
        if (trim_due_q.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding (accel %0d)",
                                    seen.accel));
        end else begin
          want = trim_due_q.pop_front();
          if (seen.accel !== want.accel)
            report_mismatch($sformatf("accel_filtered %0d, expected %0d",
                                      seen.accel, want.accel));
          if (seen.trim !== want.trim)
            report_mismatch($sformatf("trim_torque %0d, expected %0d",
                                      seen.trim, want.trim));
          if (seen.torque !== want.torque)
            report_mismatch($sformatf("torque_out %0d, expected %0d",
                                      seen.torque, want.torque));
        end
      end

      if (s_tvalid_i && s_tready_i) trim_due_q.push_back(trim_step(s_tdata_i));

      pending_o <= trim_due_q.size();
    end
  end

endmodule

[sim/traction_control_pi_trim_test.sv]
// Testbench top for traction_control_pi_trim: clock, reset, register writes, request
// and result stream traffic, and the verdict. Depends on tcpi_pkg and tcpi_trim_checker.
`timescale 1ns / 100ps

module traction_control_pi_trim_test;
  import tcpi_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned EndSettle  = 64;

  logic clk;
  logic rst_n = 1'b0;

  logic                 cfg_we    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InDataW-1:0]   s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutDataW-1:0]  m_tdata;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned req_count = 0;

  logic signed [15:0] cur_speed = '0;
  bit tx_gaps = 1'b1;

  traction_control_pi_trim dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  tcpi_trim_checker u_trim_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (s_tvalid && s_tready) req_count <= req_count + 1;
  end

  // mostly short pauses, the odd long one
  function automatic int unsigned pause_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  task automatic send_item(input logic signed [15:0] spd, input logic [9:0] dt,
                           input logic signed [15:0] treq, input logic signed [15:0] tpl);
    int unsigned gap;
    gap = (tx_gaps && $urandom_range(0, 1) == 0) ? pause_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, tpl, treq, dt, spd};
    cur_speed = spd;
    do @(posedge clk); while (!s_tready);
  endtask

  // Mostly plausible speed ramps with short ticks, the rest raw noise; long_ticks makes every tick long.
  task automatic send_random(input bit long_ticks);
    logic signed [15:0] spd;
    logic [9:0] dt;
    logic signed [15:0] treq;
    logic signed [15:0] tpl;
    int nxt;
    if ($urandom_range(0, 99) < 25) begin
      spd  = 16'($urandom);
      dt   = 10'($urandom);
      treq = 16'($urandom);
      tpl  = 16'($urandom);
    end else begin
      nxt = int'(cur_speed) + int'($urandom_range(0, 40)) - 12;
      spd = (nxt > 32767 || nxt < -32768) ? 16'($urandom) : 16'(nxt);
      dt  = ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom_range(1, 20));
      treq = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32767));
      tpl  = 16'($urandom);
    end
    if (long_ticks) dt = 10'($urandom_range(900, 1023));
    send_item(spd, dt, treq, tpl);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] w, input logic [30:0] thr,
                            input logic [15:0] kp, input logic [15:0] ki,
                            input logic [14:0] cap);
    write_reg(CfgFilterWeight, 31'(w));
    write_reg(CfgAccelThreshold, thr);
    write_reg(CfgPropGain, 31'(kp));
    write_reg(CfgIntegGain, 31'(ki));
    write_reg(CfgMaxTrim, 31'(cap));
    cfg_we <= 1'b0;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // result side: random back-pressure, plus one long hold-off early on
  initial begin : sink
    int unsigned mode_left;
    bit stalls_on;
    bit held;
    mode_left = 0;
    stalls_on = 1'b1;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stalls_on = ($urandom_range(0, 3) != 0);
        mode_left = $urandom_range(100, 400);
      end else begin
        mode_left--;
      end
      if (!held && req_count >= 40) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (stalls_on && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat (pause_len()) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults; zero tick straight out of reset
    send_item(16'sd0, 10'd0, 16'sd0, 16'sd0);
    send_item(16'sd100, 10'd1, 16'sd32767, 16'sd0);
    send_item(16'sd200, 10'd1, 16'sd32767, -16'sd32768);
    send_item(16'sd300, 10'd0, 16'sd32767, 16'sd32767);
    send_item(16'sd32767, 10'd1000, 16'sd32767, 16'sd1000);
    // negative command pulls the trim below zero
    send_item(-16'sd32768, 10'd1, -16'sd32768, 16'sd32767);
    // tick beyond the nominal range
    send_item(-16'sd32768, 10'd1023, 16'sd100, -16'sd100);
    send_item(16'sd32767, 10'd1, 16'sd32767, -16'sd32768);
    send_item(16'sd32767, 10'd0, -16'sd1, 16'sd0);
    for (int i = 0; i < 10; i++)
      send_item(16'(int'(cur_speed) + 20 - 32767 - 1000), 10'd2, 16'sd20000, 16'sd15000);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      n = 100;
      case (ph)
        0: n = 70;
        1: begin
          // weight above one, zero threshold, full gains
          set_config(16'hFFFF, 31'd0, 16'hFFFF, 16'hFFFF, 15'h7FFF);
          n = 70;
        end
        2: begin
          // latch a large acceleration, then freeze the filter so the integral saturates
          set_config(16'd32768, 31'd0, 16'd100, 16'hFFFF, 15'h7FFF);
          send_item(-16'sd32768, 10'd1, 16'sd32767, 16'sd0);
          send_item(16'sd32767, 10'd1, 16'sd32767, 16'sd0);
          drain();
          set_config(16'd0, 31'd0, 16'd100, 16'hFFFF, 15'h7FFF);
          n = 110;
        end
        3: begin
          set_config(16'd1, 31'h7FFF_FFFF, 16'd0, 16'd0, 15'd0);
          n = 60;
        end
        default: begin
          set_config(16'($urandom),
                     ($urandom_range(0, 1) != 0) ? 31'($urandom)
                                                 : 31'($urandom_range(0, 400000)),
                     16'($urandom), 16'($urandom), 15'($urandom));
        end
      endcase
      repeat (n) send_random(ph == 2);
      drain();
    end

    repeat (EndSettle) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
